// ===== hdl/bcmp_pkg.sv =====
package bcmp_pkg;

	localparam int NSTG = 10;

	typedef logic [NSTG:1] stg_vec_t;

	typedef enum logic [2:0] {
		CFG_T1   = 3'd0,
		CFG_T2   = 3'd1,
		CFG_T3   = 3'd2,
		CFG_P1   = 3'd3,
		CFG_P2   = 3'd4,
		CFG_P5   = 3'd5,
		CFG_P6   = 3'd6,
		CFG_PACK = 3'd7
	} cfg_idx_t;

	// p1m / p2m hold the calibration word minus the sensitivity bias
	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [7:0]  t3;
		logic signed [16:0] p1m;
		logic signed [16:0] p2m;
		logic        [15:0] p5;
		logic signed [15:0] p6;
		logic signed [7:0]  p3;
		logic signed [7:0]  p4;
		logic signed [7:0]  p7;
		logic signed [7:0]  p8;
		logic signed [7:0]  p10;
		logic signed [7:0]  p11;
		logic signed [15:0] p9;
	} cal_t;

	localparam logic signed [16:0] CAL_BIAS = 17'sd16384;

	localparam cal_t CAL_RESET = '{
		t1:  16'd0,
		t2:  16'sd0,
		t3:  8'sd0,
		p1m: -CAL_BIAS,
		p2m: -CAL_BIAS,
		p5:  16'd0,
		p6:  16'sd0,
		p3:  8'sd0,
		p4:  8'sd0,
		p7:  8'sd0,
		p8:  8'sd0,
		p10: 8'sd0,
		p11: 8'sd0,
		p9:  16'sd0
	};

endpackage

// ===== hdl/bcmp_cfg.sv =====
module bcmp_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	input  logic [2:0]          cfg_index,
	input  logic [63:0]         cfg_data,
	output logic                cfg_ready,
	output bcmp_pkg::cal_t      cal
);
	import bcmp_pkg::*;

	cal_t cal_q;

	assign cfg_ready = 1'b1;
	assign cal       = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= CAL_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_T1: begin
					cal_q.t1 <= cfg_data[15:0];
				end
				CFG_T2: begin
					cal_q.t2 <= $signed(cfg_data[15:0]);
				end
				CFG_T3: begin
					cal_q.t3 <= $signed(cfg_data[7:0]);
				end
				CFG_P1: begin
					cal_q.p1m <= $signed({1'b0, cfg_data[15:0]}) - CAL_BIAS;
				end
				CFG_P2: begin
					cal_q.p2m <= 17'($signed(cfg_data[15:0])) - CAL_BIAS;
				end
				CFG_P5: begin
					cal_q.p5 <= cfg_data[15:0];
				end
				CFG_P6: begin
					cal_q.p6 <= $signed(cfg_data[15:0]);
				end
				CFG_PACK: begin
					cal_q.p3  <= $signed(cfg_data[7:0]);
					cal_q.p4  <= $signed(cfg_data[15:8]);
					cal_q.p7  <= $signed(cfg_data[23:16]);
					cal_q.p8  <= $signed(cfg_data[31:24]);
					cal_q.p10 <= $signed(cfg_data[39:32]);
					cal_q.p11 <= $signed(cfg_data[47:40]);
					cal_q.p9  <= $signed(cfg_data[63:48]);
				end
			endcase
		end
	end

endmodule

// ===== hdl/bcmp_ctrl.sv =====
module bcmp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_stall,
	output bcmp_pkg::stg_vec_t  en,
	output logic                in_stall,
	output logic                out_valid
);
	import bcmp_pkg::*;

	stg_vec_t vld_q;
	logic     acc_in;
	logic     acc_out;

	// a stage loads when the output is not stalled or when it or any stage after it is empty
	for (genvar k = 1; k <= NSTG; k++) begin : g_en
		assign en[k] = !out_stall || !(&vld_q[NSTG:k]);
	end

	assign in_stall  = !en[1];
	assign out_valid = vld_q[NSTG];
	assign acc_in    = in_valid && en[1];
	assign acc_out   = vld_q[NSTG] && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> ($countones(vld_q) ==
			$past($countones(vld_q)) + 32'($past(acc_in)) - 32'($past(acc_out))))
		else $error("item count in pipeline inconsistent");

	a_hold_first: assert property (@(posedge clk) disable iff (!arst_n)
		!en[1] |=> vld_q[1])
		else $error("stalled first stage lost its item");

	a_no_repeat: assert property (@(posedge clk) disable iff (!arst_n)
		(acc_out && !vld_q[NSTG-1]) |=> !vld_q[NSTG])
		else $error("delivered item repeated");

endmodule

// ===== hdl/bcmp_tlin.sv =====
module bcmp_tlin (
	input  logic                      clk,
	input  bcmp_pkg::stg_vec_t        en,
	input  bcmp_pkg::cal_t            cal,
	input  logic [23:0]               raw_pressure,
	input  logic [23:0]               raw_temperature,
	output logic signed [22:0]        tl_s4,
	output logic [23:0]               up_s4,
	output logic signed [39:0]        s4_s4
);
	import bcmp_pkg::*;

	logic signed [24:0] d_s1;
	logic [23:0]        up_s1;
	logic [47:0]        upsq_s1;

	logic signed [40:0] dt2_s2;
	logic [47:0]        dd_s2;
	logic signed [55:0] s4p_s2;
	logic [23:0]        up_s2;

	logic signed [21:0] lin_s3;
	logic signed [48:0] qd_s3;
	logic signed [39:0] s4_s3;
	logic [23:0]        up_s3;

	logic signed [49:0] dd_full;
	logic signed [56:0] s4p_full;

	assign dd_full  = 50'(d_s1) * 50'(d_s1);
	assign s4p_full = 57'($signed({1'b0, upsq_s1})) * 57'(cal.p11);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			d_s1    <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.t1, 8'd0});
			up_s1   <= raw_pressure;
			upsq_s1 <= 48'(raw_pressure) * 48'(raw_pressure);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			dt2_s2 <= 41'(d_s1) * 41'(cal.t2);
			dd_s2  <= dd_full[47:0];
			s4p_s2 <= s4p_full[55:0];
			up_s2  <= up_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			lin_s3 <= 22'(dt2_s2 >>> 19);
			qd_s3  <= 49'($signed({1'b0, dd_s2[47:8]})) * 49'(cal.t3);
			s4_s3  <= 40'(s4p_s2 >>> 16);
			up_s3  <= up_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en[4]) begin
			tl_s4 <= 23'(lin_s3) + 23'(qd_s3 >>> 33);
			up_s4 <= up_s3;
			s4_s4 <= s4_s3;
		end
	end

endmodule

// ===== hdl/bcmp_poly.sv =====
module bcmp_poly (
	input  logic                      clk,
	input  bcmp_pkg::stg_vec_t        en,
	input  bcmp_pkg::cal_t            cal,
	input  logic signed [22:0]        tl_s4,
	input  logic [23:0]               up_s4,
	input  logic signed [39:0]        s4_s4,
	output logic signed [31:0]        temperature_centi,
	output logic signed [31:0]        pressure_pa
);
	import bcmp_pkg::*;

	// stage 5
	logic [44:0]        q_s5;
	logic signed [30:0] p10tl_s5;
	logic signed [38:0] p6tl_s5;
	logic signed [39:0] p2tl_s5;
	logic signed [17:0] temp_s5;
	logic signed [22:0] tl_s5;
	logic [23:0]        up_s5;
	logic signed [39:0] s4_s5;
	// stage 6
	logic signed [59:0] c1_s6;
	logic signed [53:0] p7q_s6;
	logic signed [53:0] p3q_s6;
	logic signed [32:0] s2p9_s6;
	logic [63:0]        offp_s6;
	logic [63:0]        sensp_s6;
	logic signed [17:0] temp_s6;
	logic [23:0]        up_s6;
	logic signed [39:0] s4_s6;
	// stage 7
	logic signed [48:0] p8c_s7;
	logic signed [48:0] p4c_s7;
	logic signed [57:0] s3m_s7;
	logic [63:0]        offa_s7;
	logic [63:0]        sensa_s7;
	logic signed [17:0] temp_s7;
	logic [23:0]        up_s7;
	logic signed [39:0] s4_s7;
	// stage 8
	logic [63:0]        off_s8;
	logic [63:0]        sens_s8;
	logic signed [44:0] s3_s8;
	logic signed [17:0] temp_s8;
	logic [23:0]        up_s8;
	logic signed [39:0] s4_s8;
	// stage 9
	logic [42:0]        base_s9;
	logic [42:0]        plo_s9;
	logic [20:0]        phi_s9;
	logic signed [17:0] temp_s9;
	// stage 10
	logic [31:0]        pres_s10;
	logic signed [17:0] temp_s10;

	logic signed [45:0] q_full;
	logic signed [25:0] t5;
	logic signed [40:0] c_val;
	logic [42:0]        sens_sh;
	logic [45:0]        plo_full;
	logic [42:0]        sum43;

	assign q_full   = 46'(tl_s4) * 46'(tl_s4);
	assign t5       = 26'(tl_s4) + (26'(tl_s4) <<< 2) + 26'sd128;
	assign c_val    = 41'(c1_s6 >>> 19);
	// only sum bits [42:0] reach the low 32 bits of the pressure
	assign sens_sh  = sens_s8[56:14];
	assign plo_full = 46'(sens_sh[21:0]) * 46'(up_s8);
	assign sum43    = base_s9 + plo_s9 + {phi_s9, 22'd0};

	assign temperature_centi = 32'(temp_s10);
	assign pressure_pa       = $signed(pres_s10);

	always_ff @(posedge clk) begin
		if (en[5]) begin
			q_s5     <= q_full[44:0];
			p10tl_s5 <= 31'(tl_s4) * 31'(cal.p10);
			p6tl_s5  <= 39'(tl_s4) * 39'(cal.p6);
			p2tl_s5  <= 40'(tl_s4) * 40'(cal.p2m);
			temp_s5  <= 18'(t5 >>> 8);
			tl_s5    <= tl_s4;
			up_s5    <= up_s4;
			s4_s5    <= s4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en[6]) begin
			c1_s6    <= 60'($signed({1'b0, q_s5[44:8]})) * 60'(tl_s5);
			p7q_s6   <= 54'($signed({1'b0, q_s5})) * 54'(cal.p7);
			p3q_s6   <= 54'($signed({1'b0, q_s5})) * 54'(cal.p3);
			s2p9_s6  <= 33'(p10tl_s5 >>> 10) + 33'($signed({cal.p9, 16'd0}));
			offp_s6  <= {1'b0, cal.p5, 47'd0} + (64'(p6tl_s5) << 22);
			sensp_s6 <= (64'(cal.p1m) << 31) + (64'(p2tl_s5) << 15);
			temp_s6  <= temp_s5;
			up_s6    <= up_s5;
			s4_s6    <= s4_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en[7]) begin
			p8c_s7   <= 49'(c_val) * 49'(cal.p8);
			p4c_s7   <= 49'(c_val) * 49'(cal.p4);
			s3m_s7   <= 58'(s2p9_s6) * 58'($signed({1'b0, up_s6}));
			offa_s7  <= offp_s6 + (64'(p7q_s6) << 4);
			sensa_s7 <= sensp_s6 + (64'(p3q_s6) << 1);
			temp_s7  <= temp_s6;
			up_s7    <= up_s6;
			s4_s7    <= s4_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			off_s8  <= offa_s7 + 64'(p8c_s7 >>> 5);
			sens_s8 <= sensa_s7 + 64'(p4c_s7 >>> 5);
			s3_s8   <= 45'(s3m_s7 >>> 13);
			temp_s8 <= temp_s7;
			up_s8   <= up_s7;
			s4_s8   <= s4_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en[9]) begin
			base_s9 <= off_s8[56:14] + 43'(s3_s8) + 43'(s4_s8);
			plo_s9  <= plo_full[42:0];
			phi_s9  <= 21'(sens_sh[42:22]) * 21'(up_s8);
			temp_s9 <= temp_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en[10]) begin
			pres_s10 <= sum43[42:11];
			temp_s10 <= temp_s9;
		end
	end

endmodule

// ===== hdl/barometric_compensation.sv =====
// Ten register stages; out_valid is the valid flag of the last of them.
// Throughput: one item per cycle while out_stall is low; the multiplier stages are fully pipelined.
// Stalls collapse bubbles: a stage takes a new item whenever it is empty.
// Reset (arst_n low): pipeline emptied, calibration returns to all-zero words.
// Calibration writes are taken on any edge with cfg_valid high (cfg_ready is always high).
module barometric_compensation (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [23:0]        raw_pressure,
	input  logic [23:0]        raw_temperature,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_centi,
	output logic signed [31:0] pressure_pa,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	import bcmp_pkg::*;

	cal_t               cal;
	stg_vec_t           en;
	logic signed [22:0] tl_s4;
	logic [23:0]        up_s4;
	logic signed [39:0] s4_s4;

	bcmp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.cal       (cal)
	);

	bcmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.en        (en),
		.in_stall  (in_stall),
		.out_valid (out_valid)
	);

	bcmp_tlin u_tlin (
		.clk             (clk),
		.en              (en),
		.cal             (cal),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.tl_s4           (tl_s4),
		.up_s4           (up_s4),
		.s4_s4           (s4_s4)
	);

	bcmp_poly u_poly (
		.clk               (clk),
		.en                (en),
		.cal               (cal),
		.tl_s4             (tl_s4),
		.up_s4             (up_s4),
		.s4_s4             (s4_s4),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa)
	);

endmodule

// ===== tb/tb_barometric_compensation.sv =====
module tb_barometric_compensation;
	timeunit 1ns;
	timeprecision 1ps;

	import bcmp_pkg::*;

	localparam int CAL_RANDOM  = 0;
	localparam int CAL_EXTREME = 1;
	localparam int CAL_TYPICAL = 2;

	typedef struct {
		bit [23:0] up;
		bit [23:0] ut;
	} sample_t;

	typedef struct {
		bit [23:0]          up;
		bit [23:0]          ut;
		logic signed [31:0] temperature;
		logic signed [31:0] pressure;
	} reading_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [23:0]        raw_pressure = '0;
	logic [23:0]        raw_temperature = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] temperature_centi;
	logic signed [31:0] pressure_pa;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = CFG_T1;
	logic [63:0]        cfg_data = '0;

	bit [63:0] cal_reg [8];
	sample_t   sample_queue [$];
	sample_t   next_sample;
	reading_t  pending_readings [$];
	reading_t  want;
	bit        in_taken, out_taken, in_burst, out_burst;
	int        in_gap, stall_cnt, mismatch_count;

	barometric_compensation u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.raw_pressure      (raw_pressure),
		.raw_temperature   (raw_temperature),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit [63:0] cal_mask(input cfg_idx_t idx);
		case (idx)
			CFG_T3:   return 64'hFF;
			CFG_PACK: return '1;
			default:  return 64'hFFFF;
		endcase
	endfunction

	// 64-bit wrapping arithmetic, arithmetic right shifts
	function automatic reading_t compensate(input bit [23:0] up_raw, input bit [23:0] ut_raw);
		longint up, ut, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
		longint d, tl, tmp, q, c, off, sens, s2, pres;
		reading_t r;
		up  = 64'(up_raw);
		ut  = 64'(ut_raw);
		t1  = 64'(cal_reg[CFG_T1][15:0]);
		t2  = 64'($signed(cal_reg[CFG_T2][15:0]));
		t3  = 64'($signed(cal_reg[CFG_T3][7:0]));
		p1  = 64'(cal_reg[CFG_P1][15:0]);
		p2  = 64'($signed(cal_reg[CFG_P2][15:0]));
		p5  = 64'(cal_reg[CFG_P5][15:0]);
		p6  = 64'($signed(cal_reg[CFG_P6][15:0]));
		p3  = 64'($signed(cal_reg[CFG_PACK][7:0]));
		p4  = 64'($signed(cal_reg[CFG_PACK][15:8]));
		p7  = 64'($signed(cal_reg[CFG_PACK][23:16]));
		p8  = 64'($signed(cal_reg[CFG_PACK][31:24]));
		p10 = 64'($signed(cal_reg[CFG_PACK][39:32]));
		p11 = 64'($signed(cal_reg[CFG_PACK][47:40]));
		p9  = 64'($signed(cal_reg[CFG_PACK][63:48]));

		d   = ut - (t1 << 8);
		tl  = ((d * t2) >>> 19) + ((((d * d) >>> 8) * t3) >>> 33);
		tmp = (tl * 5 + 128) >>> 8;
		q   = tl * tl;
		c   = ((q >>> 8) * tl) >>> 19;
		off = (p5 << 47) + ((p8 * c) >>> 5) + ((p7 * q) << 4) + ((p6 * tl) << 22);
		sens = ((p1 - 16384) << 31) + ((p4 * c) >>> 5) + ((p3 * q) << 1)
			+ (((p2 - 16384) * tl) << 15);
		s2   = (p10 * tl) >>> 10;
		pres = ((off >>> 14) + ((sens >>> 14) * up) + (((s2 + (p9 << 16)) * up) >>> 13)
			+ ((p11 * up * up) >>> 16)) >>> 11;

		r.up          = up_raw;
		r.ut          = ut_raw;
		r.temperature = tmp[31:0];
		r.pressure    = pres[31:0];
		return r;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// input side: acceptance and prediction
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall)
			pending_readings.push_back(compensate(raw_pressure, raw_temperature));
	end

	always @(negedge clk) begin
		if (!in_valid || in_taken) begin
			if (in_gap != 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (sample_queue.size() != 0) begin
				next_sample = sample_queue.pop_front();
				raw_pressure    <= next_sample.up;
				raw_temperature <= next_sample.ut;
				in_valid        <= 1'b1;
				if ($urandom_range(0, 63) == 0)
					in_burst = !in_burst;
				in_gap = in_burst ? 0 : $urandom_range(0, 16);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side: stall and check
	always @(negedge clk) begin
		if (out_taken) begin
			if ($urandom_range(0, 63) == 0)
				out_burst = !out_burst;
			stall_cnt = out_burst ? 0 : $urandom_range(0, 16);
		end
		if (stall_cnt != 0) begin
			stall_cnt--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		out_taken <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				flag_mismatch($sformatf("unexpected item temperature %0d pressure %0d",
					temperature_centi, pressure_pa));
			end else begin
				want = pending_readings.pop_front();
				if (temperature_centi !== want.temperature)
					flag_mismatch($sformatf("temperature_centi %0d, want %0d (up %h ut %h)",
						temperature_centi, want.temperature, want.up, want.ut));
				if (pressure_pa !== want.pressure)
					flag_mismatch($sformatf("pressure_pa %0d, want %0d (up %h ut %h)",
						pressure_pa, want.pressure, want.up, want.ut));
			end
		end
	end

	task automatic write_cal(input cfg_idx_t idx, input bit [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cal_reg[idx] = data & cal_mask(idx);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_cal(input bit [63:0] t1, t2, t3, p1, p2, p5, p6, pack);
		write_cal(CFG_T1, t1);
		write_cal(CFG_T2, t2);
		write_cal(CFG_T3, t3);
		write_cal(CFG_P1, p1);
		write_cal(CFG_P2, p2);
		write_cal(CFG_P5, p5);
		write_cal(CFG_P6, p6);
		write_cal(CFG_PACK, pack);
	endtask

	function automatic bit [7:0] small_byte();
		return 8'($urandom_range(0, 64) - 32);
	endfunction

	task automatic random_cal(input int kind);
		cfg_idx_t  idx;
		bit [63:0] junk, val, pos, m;
		for (int i = 0; i < 8; i++) begin
			idx  = cfg_idx_t'(i);
			m    = cal_mask(idx);
			junk = {$urandom, $urandom};
			pos  = (idx == CFG_PACK) ? 64'h7FFF_7F7F_7F7F_7F7F :
				(idx == CFG_T3) ? 64'h7F : 64'h7FFF;
			case (kind)
				CAL_RANDOM: val = junk;
				CAL_EXTREME: begin
					case ($urandom_range(0, 3))
						0:       val = '0;
						1:       val = '1;
						2:       val = pos;
						default: val = ~pos;
					endcase
				end
				default: begin
					case (idx)
						CFG_T1:  val = 64'(27000 + $urandom_range(0, 2000));
						CFG_T2:  val = 64'(18000 + $urandom_range(0, 2000));
						CFG_T3:  val = 64'($urandom_range(0, 6) - 8);
						CFG_P1:  val = 64'(14000 + $urandom_range(0, 8000));
						CFG_P2:  val = 64'(14000 + $urandom_range(0, 6000));
						CFG_P5:  val = 64'(18000 + $urandom_range(0, 12000));
						CFG_P6:  val = 64'(2000 + $urandom_range(0, 2000));
						default: val = {16'($urandom_range(0, 2000) - 1000), small_byte(),
							small_byte(), small_byte(), small_byte(), small_byte(), small_byte()};
					endcase
				end
			endcase
			write_cal(idx, (val & m) | (junk & ~m));
		end
	endtask

	task automatic push_sample(input bit [23:0] up, input bit [23:0] ut);
		sample_t s;
		s.up = up;
		s.ut = ut;
		sample_queue.push_back(s);
	endtask

	task automatic push_corners();
		push_sample(24'h000000, 24'h000000);
		push_sample(24'hFFFFFF, 24'hFFFFFF);
		push_sample(24'hFFFFFF, 24'h000000);
		push_sample(24'h000000, 24'hFFFFFF);
	endtask

	function automatic bit [23:0] corner24();
		case ($urandom_range(0, 3))
			0:       return 24'h000000;
			1:       return 24'hFFFFFF;
			2:       return 24'h1 << $urandom_range(0, 23);
			default: return ~(24'h1 << $urandom_range(0, 23));
		endcase
	endfunction

	task automatic push_random();
		int        sel;
		bit [23:0] up, ut, base;
		base = {cal_reg[CFG_T1][15:0], 8'h00};
		sel  = $urandom_range(0, 99);
		if (sel < 50) begin
			// around the calibration point, both signs of the offset
			up = 24'($urandom);
			ut = 24'(base + $urandom_range(0, 1 << 19) - (1 << 18));
		end else if (sel < 85) begin
			up = 24'($urandom);
			ut = 24'($urandom);
		end else begin
			up = corner24();
			ut = corner24();
		end
		push_sample(up, ut);
	endtask

	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (sample_queue.size() != 0 || in_valid || pending_readings.size() != 0);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// calibration at reset values
		push_sample(24'h000000, 24'h000000);
		push_sample(24'hFFFFFF, 24'hFFFFFF);
		wait_idle();

		// typical calibration, junk above the register widths
		set_cal(64'hDEAD_0000_0000_6978, 64'h0123_4567_89AB_4A38, 64'hFFFF_FFFF_FFFF_FFF9,
			64'h4E20, 64'h3A98, 64'h61A8, 64'h0BB8, 64'hFC18_0CF4_08F0_05FA);
		push_corners();
		push_sample(24'hAAAAAA, 24'h555555);
		push_sample(24'h555555, 24'hAAAAAA);
		push_sample(24'h700000, 24'h697800);
		push_sample(24'h700000, 24'h6977FF);
		push_sample(24'h700000, 24'h697801);
		wait_idle();

		set_cal('1, '1, '1, '1, '1, '1, '1, '1);
		push_corners();
		wait_idle();

		set_cal(64'h0, 64'h8000, 64'h80, 64'h0, 64'h8000, 64'h0, 64'h8000,
			64'h8000_8080_8080_8080);
		push_corners();
		wait_idle();

		set_cal(64'hFFFF, 64'h7FFF, 64'h7F, 64'hFFFF, 64'h7FFF, 64'hFFFF, 64'h7FFF,
			64'h7FFF_7F7F_7F7F_7F7F);
		push_corners();
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			random_cal(ph % 3);
			repeat (236) push_random();
			wait_idle();
		end

		repeat (3 * NSTG) @(negedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/bcmp_pkg.sv
hdl/bcmp_cfg.sv
hdl/bcmp_ctrl.sv
hdl/bcmp_tlin.sv
hdl/bcmp_poly.sv
hdl/barometric_compensation.sv
tb/tb_barometric_compensation.sv
